// ===== rtl/three_axis_stepper_phase_sequencer_assert.svh =====
// Assertion macros for the stepper phase sequencer
`ifndef THREE_AXIS_STEPPER_PHASE_SEQUENCER_ASSERT_SVH
`define THREE_AXIS_STEPPER_PHASE_SEQUENCER_ASSERT_SVH

// same-cycle implication, held off during reset
`define TASPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tasps: implication check failed");

// next-cycle implication, held off during reset
`define TASPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tasps: next-cycle check failed");

`endif

// ===== rtl/tasps_pkg.sv =====
// Types, constants and phase tables for the stepper phase sequencer
`default_nettype none

package tasps_pkg;

  localparam int AXIS_COUNT = 3;
  localparam int AXIS_W     = 2;
  localparam int IN_DATA_W  = 40;
  localparam int CFG_ADDR_W = 4;

  typedef logic [2:0] phase_t;
  typedef logic [1:0] level_t;
  typedef logic [7:0] byte_t;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_LEVEL = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_FULL_STEP_MASK = 2'd0,
    REG_OFF_THRESHOLD  = 2'd1,
    REG_LOW_THRESHOLD  = 2'd2,
    REG_MID_THRESHOLD  = 2'd3
  } reg_idx_t;

  localparam byte_t RST_OFF_THRESHOLD = 8'd0;
  localparam byte_t RST_LOW_THRESHOLD = 8'd51;
  localparam byte_t RST_MID_THRESHOLD = 8'd153;

  function automatic byte_t half_pat(level_t lvl, phase_t idx);
    byte_t row [8];
    begin
      case (lvl)
        2'd0:    row = '{8'h3F, 8'h3F, 8'h1F, 8'h1F, 8'h1B, 8'h1B, 8'h3B, 8'h3B};
        2'd1:    row = '{8'h37, 8'h36, 8'h1E, 8'h16, 8'h13, 8'h12, 8'h3A, 8'h32};
        2'd2:    row = '{8'h2F, 8'h2D, 8'h1D, 8'h0D, 8'h0B, 8'h09, 8'h39, 8'h29};
        default: row = '{8'h27, 8'h2D, 8'h1C, 8'h0D, 8'h03, 8'h09, 8'h38, 8'h29};
      endcase
      return row[idx];
    end
  endfunction

  function automatic byte_t full_pat(level_t lvl, logic [1:0] idx);
    byte_t row [4];
    begin
      case (lvl)
        2'd0:    row = '{8'h3F, 8'h3B, 8'h1B, 8'h1F};
        2'd1:    row = '{8'h36, 8'h32, 8'h12, 8'h16};
        2'd2:    row = '{8'h2D, 8'h29, 8'h09, 8'h0D};
        default: row = '{8'h24, 8'h20, 8'h00, 8'h04};
      endcase
      return row[idx];
    end
  endfunction

  // pattern plus axis address in the top two bits
  function automatic byte_t axis_cmd(level_t lvl, phase_t ph, logic full,
                                     logic [AXIS_W-1:0] axis);
    byte_t pat;
    begin
      pat = full ? full_pat(lvl, ph[1:0]) : half_pat(lvl, ph);
      return pat + {axis, 6'b0};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/three_axis_stepper_phase_sequencer.sv =====
// An accepted word waits in the input stage, then its command bytes load into the result buffer that drives out_*.
// Throughput: one input word per cycle when it yields at most one command byte and out_tready
// stays high; a step word with k nonzero counts holds the result buffer until its k bytes drain,
// one byte per cycle while out_tready is high. Reset (synchronous, rst_n low): phase indices
// and current levels go to zero, config registers to their defaults, input and result stages empty.
`default_nettype none

module three_axis_stepper_phase_sequencer (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: steps_x[7:0], steps_y[15:8], steps_z[23:16], direction_bits[26:24],
  //           target_axis[29:27], level_value[37:30], force_output[38], zero[39]
  input  wire logic [tasps_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                                in_tuser,  // opcode
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  output logic [7:0]                               out_tdata, // command_byte
  output logic                                     out_tlast, // last_of_run
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tasps_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);
  import tasps_pkg::*;

  `include "three_axis_stepper_phase_sequencer_assert.svh"

  // config registers
  logic [2:0] fsm_r;
  byte_t      off_thr_r, low_thr_r, mid_thr_r;
  reg_idx_t   reg_idx;
  logic       cfg_wr;

  // axis state
  phase_t phase_r [AXIS_COUNT];
  phase_t phase_nxt [AXIS_COUNT];
  level_t level_r [AXIS_COUNT];
  level_t level_nxt [AXIS_COUNT];

  // input stage
  logic                 s1_vld_r;
  op_t                  s1_op_r;
  logic [IN_DATA_W-1:0] s1_data_r;
  logic                 s1_mv;

  // result buffer, head at entry 0
  byte_t      buf_r [AXIS_COUNT];
  byte_t      buf_nxt [AXIS_COUNT];
  logic [1:0] rem_r;
  logic [1:0] rem_nxt;
  logic       pop;

  // unpacked fields of the staged word
  byte_t             steps [AXIS_COUNT];
  logic [2:0]        dir;
  logic [2:0]        tgt;
  byte_t             lvl_in;
  logic              force_out;
  logic              tgt_ok;
  logic [AXIS_W-1:0] tgt_i;
  level_t            lvl_q;
  byte_t             slot [AXIS_COUNT];
  logic [1:0]        n_res;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r     <= '0;
      off_thr_r <= RST_OFF_THRESHOLD;
      low_thr_r <= RST_LOW_THRESHOLD;
      mid_thr_r <= RST_MID_THRESHOLD;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FULL_STEP_MASK: fsm_r     <= pwdata[2:0];
        REG_OFF_THRESHOLD:  off_thr_r <= pwdata[7:0];
        REG_LOW_THRESHOLD:  low_thr_r <= pwdata[7:0];
        REG_MID_THRESHOLD:  mid_thr_r <= pwdata[7:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FULL_STEP_MASK: prdata = {29'b0, fsm_r};
      REG_OFF_THRESHOLD:  prdata = {24'b0, off_thr_r};
      REG_LOW_THRESHOLD:  prdata = {24'b0, low_thr_r};
      REG_MID_THRESHOLD:  prdata = {24'b0, mid_thr_r};
      default:            prdata = '0;
    endcase
  end

  // staged word moves on once the buffer is empty or drains its last byte now
  assign pop       = out_tvalid && out_tready;
  assign s1_mv     = s1_vld_r && ((rem_r == 2'd0) || ((rem_r == 2'd1) && out_tready));
  assign in_tready = !s1_vld_r || s1_mv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= op_t'(in_tuser);
      s1_data_r <= in_tdata;
    end
  end

  assign steps[0]  = s1_data_r[7:0];
  assign steps[1]  = s1_data_r[15:8];
  assign steps[2]  = s1_data_r[23:16];
  assign dir       = s1_data_r[26:24];
  assign tgt       = s1_data_r[29:27];
  assign lvl_in    = s1_data_r[37:30];
  assign force_out = s1_data_r[38];
  assign tgt_ok    = tgt < 3'(AXIS_COUNT);
  assign tgt_i     = tgt[AXIS_W-1:0];

  // thresholds are checked top-down so a non-ascending set still decides
  always_comb begin
    if (lvl_in > mid_thr_r)      lvl_q = 2'd3;
    else if (lvl_in > low_thr_r) lvl_q = 2'd2;
    else if (lvl_in > off_thr_r) lvl_q = 2'd1;
    else                         lvl_q = 2'd0;
  end

  always_comb begin
    phase_nxt = phase_r;
    level_nxt = level_r;
    slot      = '{default: '0};
    n_res     = '0;
    if (s1_op_r == OP_STEP) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        if (steps[a] != 8'd0) begin
          phase_nxt[a] = dir[a] ? phase_r[a] + steps[a][2:0]
                                : phase_r[a] - steps[a][2:0];
          slot[n_res]  = axis_cmd(level_r[a], phase_nxt[a], fsm_r[a], AXIS_W'(a));
          n_res        = n_res + 2'd1;
        end
      end
    end else if (tgt_ok) begin
      level_nxt[tgt_i] = lvl_q;
      if (force_out) begin
        slot[0] = axis_cmd(lvl_q, phase_r[tgt_i], fsm_r[tgt_i], tgt_i);
        n_res   = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        phase_r[a] <= '0;
        level_r[a] <= '0;
      end
    end else if (s1_mv) begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
    end
  end

  always_comb begin
    buf_nxt = buf_r;
    rem_nxt = rem_r;
    if (s1_mv) begin
      buf_nxt = slot;
      rem_nxt = n_res;
    end else if (pop) begin
      for (int i = 0; i < AXIS_COUNT - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      rem_nxt = rem_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign out_tvalid = rem_r != 2'd0;
  assign out_tdata  = buf_r[0];
  assign out_tlast  = rem_r == 2'd1;

  // a new word never lands on bytes still waiting
  `TASPS_ASSERT_IMP(a_no_overwrite, s1_mv, (rem_r == 2'd0) || (rem_r == 2'd1 && out_tready))
  // a step on axis 0 puts axis 0's byte at the head
  `TASPS_ASSERT_NXT(a_x_first, s1_mv && s1_op_r == OP_STEP && steps[0] != 8'd0,
                    out_tvalid && out_tdata[7:6] == 2'd0)
  // no command byte ever carries the unused axis address
  `TASPS_ASSERT_IMP(a_axis_addr, out_tvalid, out_tdata[7:6] != 2'd3)

endmodule

`default_nettype wire
